// File: src/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg: shared types and constants for the stack with search
// Command and status codes, transfer payload structs, default capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

  localparam int unsigned SWS_DEPTH_DEF = 64;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned COUNT_W       = 7;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RSVD  = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SRCH = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] value;
  } sws_in_t;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic               is_empty;
    logic [COUNT_W-1:0] count;
  } sws_out_t;

endpackage

`default_nettype wire

// File: src/sws_mem.sv
// ----------------------------------------------------------------------------
// sws_mem: entry storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_mem import sws_pkg::*; #(
  parameter int unsigned DEPTH = SWS_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: src/sws_ctrl.sv
// ----------------------------------------------------------------------------
// sws_ctrl: command sequencer
// Keeps the fill count, writes pushes, scans entries one per cycle on search
// and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_ctrl import sws_pkg::*; #(
  parameter int unsigned DEPTH = SWS_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned FW    = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire sws_in_t           in_item,
  output logic                   out_valid,
  output sws_out_t               out_item,
  output logic                   wr_en,
  output logic      [AW-1:0]     wr_addr,
  output logic      [WORD_W-1:0] wr_data,
  output logic                   rd_en,
  output logic      [AW-1:0]     rd_addr,
  input  wire logic [WORD_W-1:0] rd_data
);

  localparam logic [FW-1:0] FULL_CNT = FW'(DEPTH);

  state_t            state_r, state_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;
  logic              out_valid_r, out_valid_nxt;
  sws_out_t          out_r, out_nxt;
  logic              accept;
  logic              hit;
  logic              last;

  assign accept = start && (state_r == ST_IDLE);
  assign hit    = (rd_data == key_r);
  assign last   = ((FW'(idx_r) + FW'(1)) == fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = AW'(fill_r);
    wr_data       = in_item.value;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt.status = STAT_DONE;
          out_nxt.found  = 1'b0;
          case (in_item.cmd)
            CMD_PUSH: begin
              if (fill_r == FULL_CNT) begin
                out_nxt.status = STAT_FULL;
              end else begin
                wr_en    = 1'b1;
                fill_nxt = fill_r + FW'(1);
              end
            end
            CMD_POP: begin
              if (fill_r == '0) begin
                out_nxt.status = STAT_EMPTY;
              end else begin
                fill_nxt = fill_r - FW'(1);
              end
            end
            CMD_SEARCH: begin
              if (fill_r != '0) begin
                rd_en     = 1'b1;
                idx_nxt   = '0;
                key_nxt   = in_item.value;
                state_nxt = ST_SRCH;
              end
            end
            default: ;
          endcase
          out_valid_nxt    = (state_nxt == ST_IDLE);
          out_nxt.is_empty = (fill_nxt == '0);
          out_nxt.count    = COUNT_W'(fill_nxt);
        end
      end
      ST_SRCH: begin
        if (hit || last) begin
          state_nxt        = ST_IDLE;
          out_valid_nxt    = 1'b1;
          out_nxt.status   = STAT_DONE;
          out_nxt.found    = hit;
          out_nxt.is_empty = 1'b0;
          out_nxt.count    = COUNT_W'(fill_r);
        end else begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + AW'(1);
          rd_addr = idx_nxt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT) else $error("fill count beyond capacity");

  a_srch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (fill_r != '0)) else $error("scan over empty store");

  a_srch_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (FW'(idx_r) < fill_r)) else $error("scan index past top");

  a_found_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.found) |-> $past(state_r == ST_SRCH))
    else $error("found set outside a search");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == STAT_FULL) |-> (out_r.count == COUNT_W'(DEPTH)))
    else $error("full status with short count");

endmodule

`default_nettype wire

// File: src/stack_with_search.sv
// ----------------------------------------------------------------------------
// stack_with_search: LIFO store of 32-bit words with linear search
// Push, pop or search per command; one result per command.
// ----------------------------------------------------------------------------
//  Channel | Ports                    | Transfer
//  --------+--------------------------+------------------------------------
//  input   | start, busy, in_item     | start high while busy low
//  result  | out_valid, out_item      | out_valid high, one cycle, no stall
//
//  Push, pop and unused codes: result in the cycle after the transfer; the next
//  command may follow in the next cycle.
//  Search: the memory read port scans one entry per cycle from the bottom;
//  busy stays high while entries are compared (1..DEPTH of them, up to the
//  first match), result in the first cycle with busy low again. Empty
//  store: busy stays low, result in the cycle after the transfer.
//  Reset (rst_n low, synchronous) empties the store; no clearing pass.
//  The receiver cannot stall; busy is the only backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_search import sws_pkg::*; #(
  parameter int unsigned DEPTH = SWS_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire sws_in_t in_item,
  output logic         out_valid,
  output sws_out_t     out_item
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  sws_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .FW    (FW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  sws_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
